>>> rtl/core/dsyd_pkg.sv
// dsyd_pkg: widths, codes and tables shared by the date string parser
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package dsyd_pkg;

   // field widths
   localparam int CH_W    = 8;
   localparam int YEAR_W  = 20;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DOY_W   = 9;
   localparam int STAT_W  = 3;
   localparam int CNT_W   = 4;
   localparam int SEG_W   = 7;
   localparam int NUMY_W  = 14;
   localparam int REM_W   = 5;

   // longest string accepted, prefix included
   localparam logic [CNT_W-1:0] MAX_CHARS = 4'd11;
   localparam logic [CNT_W-1:0] CNT_SAT   = 4'd15;

   // saturation caps of the segment accumulators
   localparam logic [YEAR_W-1:0] YEAR_CAP = 20'd999999;
   localparam logic [SEG_W-1:0]  SEG_CAP  = 7'd127;
   // 999999 mod 25
   localparam logic [REM_W-1:0]  YEAR_CAP_REM25 = 5'd24;

   // characters of interest
   localparam logic [CH_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CH_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CH_W-1:0] CHAR_M      = 8'h6d;
   localparam logic [CH_W-1:0] CHAR_D      = 8'h64;
   localparam logic [CH_W-1:0] CHAR_PREFIX = 8'h61;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_FULL      = 3'd0,
      ST_YEAR      = 3'd1,
      ST_MALFORMED = 3'd2,
      ST_ILLEGAL   = 3'd3,
      ST_MARKER    = 3'd4,
      ST_RANGE     = 3'd5,
      ST_LEAP_FEB  = 3'd6
   } status_type;

   // first sticky error seen while parsing
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MALFORMED = 2'd1,
      ERR_ILLEGAL   = 2'd2
   } err_type;

   // which segment digits currently go to
   typedef enum logic [1:0] {
      SEG_YEAR  = 2'd0,
      SEG_MONTH = 2'd1,
      SEG_DAY   = 2'd2
   } seg_type;

   // first day of each month, normal and leap years
   localparam logic [DOY_W-1:0] NORM_FIRST [12] = '{
      9'd1, 9'd32, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};
   localparam logic [DOY_W-1:0] LEAP_FIRST [12] = '{
      9'd1, 9'd32, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd183, 9'd214, 9'd245, 9'd275, 9'd306, 9'd336};

   // first day of month index (0 = january); zero for indexes past december
   function automatic logic [DOY_W-1:0] first_day(input logic leap,
                                                  input logic [3:0] idx);
      logic [DOY_W-1:0] val;
      val = '0;
      if (idx < 4'd12) begin
         val = leap ? LEAP_FIRST[idx] : NORM_FIRST[idx];
      end
      return val;
   endfunction

   // remainder by 25 of a value below 250, via reciprocal 41/1024
   function automatic logic [REM_W-1:0] mod25(input logic [7:0] v);
      logic [13:0] prod;
      logic [3:0]  quot;
      logic [7:0]  sub;
      logic [7:0]  rem;
      prod = {6'd0, v} * 14'd41;
      quot = prod[13:10];
      sub  = {4'd0, quot} * 8'd25;
      rem  = v - sub;
      return rem[REM_W-1:0];
   endfunction

   // next remainder by 25 after appending one decimal digit
   function automatic logic [REM_W-1:0] rem25_step(input logic [REM_W-1:0] r,
                                                   input logic [3:0] dv);
      logic [7:0] v;
      v = {3'd0, r} * 8'd10 + {4'd0, dv};
      return mod25(v);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/dsyd_req_if.sv
// dsyd_req_if: character channel, one character and a last flag per word
// depends on dsyd_pkg
`default_nettype none

interface dsyd_req_if;
   import dsyd_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            last;

   modport source(output valid, ch, last, input ready);
   modport sink(input valid, ch, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dsyd_rsp_if.sv
// dsyd_rsp_if: result channel, status and parsed date per word
// depends on dsyd_pkg
`default_nettype none

interface dsyd_rsp_if;
   import dsyd_pkg::*;

   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0] month;
   logic [DAY_W-1:0]   day;
   logic [DOY_W-1:0]   day_of_year;

   modport source(output valid, status, year, month, day, day_of_year, input ready);
   modport sink(input valid, status, year, month, day, day_of_year, output ready);
endinterface

`default_nettype wire

>>> rtl/core/date_string_to_year_day.sv
// date_string_to_year_day: parses a date string one character a word and
// returns status, year, month, day and day of year; uses dsyd_pkg, dsyd_req_if, dsyd_rsp_if
//
//   channel   direction  word contents
//   req_bus   in         ch (8), last (1)
//   rsp_bus   out        status (3), year (20), month (4), day (5), day_of_year (9)
//   csr_*     in         julian_last_year (20), write only
//
// One character is taken every cycle while req_bus.ready is high; parse state updates in that same cycle.
// The last character loads a snapshot register; the date check and day of year
// lookup run from it into the result register, which loads from the snapshot
// once the result stage is free.
// Reset is synchronous and returns the parser and julian_last_year (1582) to start.
// A held result stalls the snapshot stage, which in turn drops req_bus.ready.
`default_nettype none

module date_string_to_year_day (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [dsyd_pkg::YEAR_W-1:0] csr_wdata,
   dsyd_req_if.sink                    req_bus,
   dsyd_rsp_if.source                  rsp_bus
);
   import dsyd_pkg::*;

   // configuration
   logic [YEAR_W-1:0] jly_ff;

   // parse state
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              prefix_ff, prefix_in;
   logic              only_dig_ff, only_dig_in;
   err_type           err_ff, err_in;
   logic              m_seen_ff, m_seen_in;
   logic              d_seen_ff, d_seen_in;
   seg_type           seg_ff, seg_in;
   logic [YEAR_W-1:0] seg_year_ff, seg_year_in;
   logic [REM_W-1:0]  seg_rem_ff, seg_rem_in;
   logic [SEG_W-1:0]  seg_month_ff, seg_month_in;
   logic [SEG_W-1:0]  seg_day_ff, seg_day_in;
   logic [NUMY_W-1:0] num_year_ff, num_year_in;
   logic [REM_W-1:0]  num_rem_ff, num_rem_in;
   logic [SEG_W-1:0]  num_month_ff, num_month_in;
   logic [SEG_W-1:0]  num_day_ff, num_day_in;

   // snapshot stage
   logic              snap_valid_ff, snap_valid_in;
   logic              snap_chk_ff, snap_chk_in;
   status_type        snap_status_ff, snap_status_in;
   logic [YEAR_W-1:0] snap_year_ff, snap_year_in;
   logic [SEG_W-1:0]  snap_month_ff, snap_month_in;
   logic [SEG_W-1:0]  snap_day_ff, snap_day_in;
   logic [REM_W-1:0]  snap_rem_ff, snap_rem_in;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [YEAR_W-1:0]  rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0] rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]   rsp_day_ff, rsp_day_in;
   logic [DOY_W-1:0]   rsp_doy_ff, rsp_doy_in;

   // handshake
   logic rsp_free;
   logic snap_free;
   logic req_acc;
   logic last_acc;

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign snap_free     = !snap_valid_ff || rsp_free;
   assign req_bus.ready = snap_free;
   assign req_acc       = req_bus.valid && snap_free;
   assign last_acc      = req_acc && req_bus.last;

   // character classification and accumulator steps
   logic              is_digit;
   logic [3:0]        dv;
   logic              take_prefix;
   logic [CNT_W-1:0]  pos;
   logic [23:0]       year_wide;
   logic [10:0]       month_wide;
   logic [10:0]       day_wide;
   logic              year_sat;

   assign is_digit    = (req_bus.ch >= CHAR_ZERO) && (req_bus.ch <= CHAR_NINE);
   assign dv          = is_digit ? req_bus.ch[3:0] : 4'd0;
   assign take_prefix = (cnt_ff == '0) && (req_bus.ch == CHAR_PREFIX);
   assign pos         = cnt_ff - {{(CNT_W-1){1'b0}}, prefix_ff};
   assign year_wide   = {4'd0, seg_year_ff} * 24'd10 + {20'd0, dv};
   assign month_wide  = {4'd0, seg_month_ff} * 11'd10 + {7'd0, dv};
   assign day_wide    = {4'd0, seg_day_ff} * 11'd10 + {7'd0, dv};
   assign year_sat    = year_wide > {4'd0, YEAR_CAP};

   // next parse state for the current character
   always_comb begin
      prefix_in    = prefix_ff;
      only_dig_in  = only_dig_ff;
      err_in       = err_ff;
      m_seen_in    = m_seen_ff;
      d_seen_in    = d_seen_ff;
      seg_in       = seg_ff;
      seg_year_in  = seg_year_ff;
      seg_rem_in   = seg_rem_ff;
      seg_month_in = seg_month_ff;
      seg_day_in   = seg_day_ff;
      num_year_in  = num_year_ff;
      num_rem_in   = num_rem_ff;
      num_month_in = num_month_ff;
      num_day_in   = num_day_ff;
      cnt_in       = (cnt_ff < CNT_SAT) ? cnt_ff + 4'd1 : cnt_ff;

      if (take_prefix) begin
         prefix_in = 1'b1;
      end else if (pos == '0 && !is_digit) begin
         only_dig_in = 1'b0;
         if (err_ff == ERR_NONE) begin
            err_in = ERR_MALFORMED;
         end
      end else if (is_digit) begin
         // marker-form segments, saturating
         case (seg_ff)
            SEG_YEAR: begin
               seg_year_in = year_sat ? YEAR_CAP : year_wide[YEAR_W-1:0];
               seg_rem_in  = year_sat ? YEAR_CAP_REM25 : rem25_step(seg_rem_ff, dv);
            end
            SEG_MONTH: begin
               seg_month_in = (month_wide > {4'd0, SEG_CAP}) ? SEG_CAP
                                                            : month_wide[SEG_W-1:0];
            end
            default: begin
               seg_day_in = (day_wide > {4'd0, SEG_CAP}) ? SEG_CAP
                                                        : day_wide[SEG_W-1:0];
            end
         endcase
         // fixed-position YYYYMMDD fields
         if (pos < 4'd4) begin
            num_year_in = num_year_ff * 14'd10 + {10'd0, dv};
            num_rem_in  = rem25_step(num_rem_ff, dv);
         end else if (pos < 4'd6) begin
            num_month_in = num_month_ff * 7'd10 + {3'd0, dv};
         end else if (pos < 4'd8) begin
            num_day_in = num_day_ff * 7'd10 + {3'd0, dv};
         end
      end else begin
         only_dig_in = 1'b0;
         if (req_bus.ch == CHAR_M && !m_seen_ff) begin
            m_seen_in = 1'b1;
            seg_in    = SEG_MONTH;
         end else if (req_bus.ch == CHAR_D && !d_seen_ff) begin
            d_seen_in = 1'b1;
            seg_in    = SEG_DAY;
         end else if (err_ff == ERR_NONE) begin
            err_in = ERR_ILLEGAL;
         end
      end
   end

   // classify the finished string into a direct status or a date to check
   logic [CNT_W-1:0] len;

   assign len = cnt_in - {{(CNT_W-1){1'b0}}, prefix_in};

   always_comb begin
      snap_chk_in    = 1'b0;
      snap_status_in = ST_MALFORMED;
      snap_year_in   = seg_year_in;
      snap_month_in  = seg_month_in;
      snap_day_in    = seg_day_in;
      snap_rem_in    = seg_rem_in;
      if (cnt_in > MAX_CHARS || len == '0 || err_in == ERR_MALFORMED) begin
         snap_status_in = ST_MALFORMED;
      end else if (only_dig_in) begin
         snap_year_in  = {{(YEAR_W-NUMY_W){1'b0}}, num_year_in};
         snap_month_in = num_month_in;
         snap_day_in   = num_day_in;
         snap_rem_in   = num_rem_in;
         if (len < 4'd5) begin
            snap_status_in = ST_YEAR;
         end else if (len == 4'd8) begin
            snap_chk_in = 1'b1;
         end
      end else if (err_in == ERR_ILLEGAL) begin
         snap_status_in = ST_ILLEGAL;
      end else if (m_seen_in != d_seen_in) begin
         snap_status_in = ST_MARKER;
      end else if (!m_seen_in) begin
         snap_status_in = ST_ILLEGAL;
      end else begin
         snap_chk_in = 1'b1;
      end
   end

   // date check and day of year from the snapshot
   logic             gregorian;
   logic             div4;
   logic             div100;
   logic             div400;
   logic             leap;
   logic             bad_range;
   logic             short_month;
   logic [3:0]       month_idx;
   logic [DOY_W-1:0] doy_calc;

   assign gregorian   = snap_year_ff > jly_ff;
   assign div4        = (snap_year_ff[1:0] == 2'd0);
   assign div100      = div4 && (snap_rem_ff == '0);
   assign div400      = (snap_year_ff[3:0] == 4'd0) && (snap_rem_ff == '0);
   assign leap        = gregorian ? (div400 || (div4 && !div100)) : div4;
   assign bad_range   = (snap_month_ff < 7'd1) || (snap_month_ff > 7'd12) ||
                        (snap_day_ff < 7'd1) || (snap_day_ff > 7'd31);
   assign short_month = (snap_month_ff == 7'd4) || (snap_month_ff == 7'd6) ||
                        (snap_month_ff == 7'd9) || (snap_month_ff == 7'd11);
   assign month_idx   = snap_month_ff[3:0] - 4'd1;
   assign doy_calc    = first_day(leap, month_idx) + {2'd0, snap_day_ff} - 9'd1;

   always_comb begin
      rsp_status_in = snap_status_ff;
      rsp_year_in   = (snap_status_ff == ST_YEAR) ? snap_year_ff : '0;
      rsp_month_in  = '0;
      rsp_day_in    = '0;
      rsp_doy_in    = '0;
      if (snap_chk_ff) begin
         rsp_year_in = '0;
         if (bad_range) begin
            rsp_status_in = ST_RANGE;
         end else if (snap_month_ff == 7'd2 && leap && snap_day_ff > 7'd29) begin
            rsp_status_in = ST_LEAP_FEB;
         end else if (snap_month_ff == 7'd2 && !leap && snap_day_ff > 7'd28) begin
            rsp_status_in = ST_RANGE;
         end else if (short_month && snap_day_ff > 7'd30) begin
            rsp_status_in = ST_RANGE;
         end else begin
            rsp_status_in = ST_FULL;
            rsp_year_in   = snap_year_ff;
            rsp_month_in  = snap_month_ff[MONTH_W-1:0];
            rsp_day_in    = snap_day_ff[DAY_W-1:0];
            rsp_doy_in    = doy_calc;
         end
      end
   end

   // stage valid flags
   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (last_acc) begin
         snap_valid_in = 1'b1;
      end else if (rsp_free) begin
         snap_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_free ? snap_valid_ff : rsp_valid_ff;
   end

   // control and parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         jly_ff        <= 20'd1582;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         prefix_ff     <= 1'b0;
         only_dig_ff   <= 1'b1;
         err_ff        <= ERR_NONE;
         m_seen_ff     <= 1'b0;
         d_seen_ff     <= 1'b0;
         seg_ff        <= SEG_YEAR;
         seg_year_ff   <= '0;
         seg_rem_ff    <= '0;
         seg_month_ff  <= '0;
         seg_day_ff    <= '0;
         num_year_ff   <= '0;
         num_rem_ff    <= '0;
         num_month_ff  <= '0;
         num_day_ff    <= '0;
      end else begin
         if (csr_we) begin
            jly_ff <= csr_wdata;
         end
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (last_acc) begin
            cnt_ff       <= '0;
            prefix_ff    <= 1'b0;
            only_dig_ff  <= 1'b1;
            err_ff       <= ERR_NONE;
            m_seen_ff    <= 1'b0;
            d_seen_ff    <= 1'b0;
            seg_ff       <= SEG_YEAR;
            seg_year_ff  <= '0;
            seg_rem_ff   <= '0;
            seg_month_ff <= '0;
            seg_day_ff   <= '0;
            num_year_ff  <= '0;
            num_rem_ff   <= '0;
            num_month_ff <= '0;
            num_day_ff   <= '0;
         end else if (req_acc) begin
            cnt_ff       <= cnt_in;
            prefix_ff    <= prefix_in;
            only_dig_ff  <= only_dig_in;
            err_ff       <= err_in;
            m_seen_ff    <= m_seen_in;
            d_seen_ff    <= d_seen_in;
            seg_ff       <= seg_in;
            seg_year_ff  <= seg_year_in;
            seg_rem_ff   <= seg_rem_in;
            seg_month_ff <= seg_month_in;
            seg_day_ff   <= seg_day_in;
            num_year_ff  <= num_year_in;
            num_rem_ff   <= num_rem_in;
            num_month_ff <= num_month_in;
            num_day_ff   <= num_day_in;
         end
      end
   end

   // snapshot and result payload
   always_ff @(posedge clock) begin
      if (last_acc) begin
         snap_chk_ff    <= snap_chk_in;
         snap_status_ff <= snap_status_in;
         snap_year_ff   <= snap_year_in;
         snap_month_ff  <= snap_month_in;
         snap_day_ff    <= snap_day_in;
         snap_rem_ff    <= snap_rem_in;
      end
      if (rsp_free && snap_valid_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_year_ff   <= rsp_year_in;
         rsp_month_ff  <= rsp_month_in;
         rsp_day_ff    <= rsp_day_in;
         rsp_doy_ff    <= rsp_doy_in;
      end
   end

   // result port
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.year        = rsp_year_ff;
   assign rsp_bus.month       = rsp_month_ff;
   assign rsp_bus.day         = rsp_day_ff;
   assign rsp_bus.day_of_year = rsp_doy_ff;

   // a snapshot only appears after a last character was taken
   a_snap_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(snap_valid_ff) |-> $past(last_acc))
      else $error("snapshot loaded without a last character");

   // parser is back at its start state after a last character
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      last_acc |=> (cnt_ff == '0) && only_dig_ff && (err_ff == ERR_NONE) &&
                   !m_seen_ff && !d_seen_ff && (seg_ff == SEG_YEAR))
      else $error("parse state not cleared after last character");

   // a full date carries a month, a day and a day of year
   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |->
         (rsp_month_ff != '0) && (rsp_day_ff != '0) && (rsp_doy_ff != '0))
      else $error("full date with empty fields");

   // anything but a full date carries no month, day or day of year
   a_other_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_FULL) |->
         (rsp_month_ff == '0) && (rsp_day_ff == '0) && (rsp_doy_ff == '0))
      else $error("non-full result with date fields set");

   // an empty snapshot stage never blocks characters
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !snap_valid_ff |-> req_bus.ready)
      else $error("character channel stalled with empty pipeline");

endmodule

`default_nettype wire
